FILE: src/dbba_pkg.sv
package dbba_pkg;

  // default number of disk blocks tracked by the bitmap
  localparam int unsigned NUM_BLOCKS_DEF = 128;

  // operation codes carried in the kind field
  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_FORMAT = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  // result status codes
  typedef enum logic {
    STATUS_OK       = 1'b0,
    STATUS_NO_SPACE = 1'b1
  } status_e;

  // controls fanned out from the sequencer to every bitmap cell
  typedef struct packed {
    logic shift;  // rotate the ring by one cell
    logic clear;  // mark every block free
  } chain_ctrl_t;

endpackage

FILE: src/dbba_in_if.sv
interface dbba_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] block_count;
  logic [6:0] first_block;

  modport source (output valid, output kind, output block_count, output first_block,
                  input ready);
  modport sink (input valid, input kind, input block_count, input first_block,
                output ready);
endinterface

FILE: src/dbba_out_if.sv
interface dbba_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [6:0] start_block;
  logic [7:0] free_count;

  modport source (output valid, output status, output start_block, output free_count,
                  input ready);
  modport sink (input valid, input status, input start_block, input free_count,
                output ready);
endinterface

FILE: src/disk_block_bitmap_allocator_core.sv
// Allocate and free accept an item, rotate the bitmap ring one cell past the sequencer
//   each cycle in the scan state, then load the result register from the finish state;
//   format, status and a failed allocate go straight from accept to the finish state.
//   A new item is accepted only in the idle state, once the last has loaded its result.
//   A result held by the receiver stalls a later item in its finish state until taken.
// Reset: every block free, free count NUM_BLOCKS, no result pending.
module disk_block_bitmap_allocator_core #(
  parameter int unsigned NUM_BLOCKS = dbba_pkg::NUM_BLOCKS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dbba_in_if.sink    req_i,
  dbba_out_if.source rsp_o
);

  localparam int unsigned IDXW = $clog2(NUM_BLOCKS);
  localparam int unsigned FCW  = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned CW   = ((IDXW > 9) ? IDXW : 9) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e                state_q;
  logic                  op_alloc_q;
  logic [IDXW-1:0]       idx_q;
  logic [7:0]            want_q;
  logic [7:0]            got_q;
  logic [6:0]            first_q;
  logic [7:0]            count_q;
  logic [IDXW-1:0]       lowest_q;
  dbba_pkg::status_e     status_q;
  logic [FCW-1:0]        free_q;
  logic                  out_valid_q;
  logic                  out_status_q;
  logic [6:0]            out_start_q;
  logic [7:0]            out_free_q;

  dbba_pkg::chain_ctrl_t chain_ctrl;
  logic                  head;
  logic                  tail;
  logic                  in_acc;
  logic                  no_space;
  logic                  take;
  logic                  release_blk;
  logic                  in_range;
  logic [CW-1:0]         idx_ext;
  logic [CW-1:0]         end_ext;
  logic                  out_free_slot;
  logic [31:0]           lowest_w;
  logic [31:0]           free_w;

  assign in_acc        = req_i.valid && req_i.ready;
  assign req_i.ready   = (state_q == ST_IDLE);
  assign out_free_slot = !out_valid_q || rsp_o.ready;
  assign no_space      = ({{(CW-8){1'b0}}, req_i.block_count} > CW'(free_q));

  // per-block decision on the bit at the head of the ring
  always_comb begin
    idx_ext     = CW'(idx_q);
    end_ext     = CW'(first_q) + CW'(count_q);
    in_range    = (idx_ext >= CW'(first_q)) && (idx_ext < end_ext);
    take        = op_alloc_q && !head && (got_q < want_q);
    release_blk = !op_alloc_q && head && in_range;
    tail        = (head | take) & ~release_blk;
  end

  assign chain_ctrl.shift = (state_q == ST_SCAN);
  assign chain_ctrl.clear = in_acc && (req_i.kind == dbba_pkg::KIND_FORMAT);

  dbba_chain #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (chain_ctrl),
    .tail_i (tail),
    .head_o (head)
  );

  // low bits of the block index and free count as reported
  assign lowest_w = 32'(lowest_q);
  assign free_w   = 32'(free_q);

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_alloc_q   <= 1'b0;
      idx_q        <= '0;
      want_q       <= '0;
      got_q        <= '0;
      first_q      <= '0;
      count_q      <= '0;
      lowest_q     <= '0;
      status_q     <= dbba_pkg::STATUS_OK;
      free_q       <= FCW'(NUM_BLOCKS);
      out_valid_q  <= 1'b0;
      out_status_q <= 1'b0;
      out_start_q  <= '0;
      out_free_q   <= '0;
    end else begin
      // a finishing item reloads the result register itself
      if (out_valid_q && rsp_o.ready && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            idx_q      <= '0;
            got_q      <= '0;
            lowest_q   <= '0;
            want_q     <= req_i.block_count;
            count_q    <= req_i.block_count;
            first_q    <= req_i.first_block;
            op_alloc_q <= (req_i.kind == dbba_pkg::KIND_ALLOC);
            unique case (req_i.kind)
              dbba_pkg::KIND_ALLOC: begin
                if (no_space) begin
                  status_q <= dbba_pkg::STATUS_NO_SPACE;
                  state_q  <= ST_FINISH;
                end else begin
                  status_q <= dbba_pkg::STATUS_OK;
                  state_q  <= ST_SCAN;
                end
              end
              dbba_pkg::KIND_FREE: begin
                status_q <= dbba_pkg::STATUS_OK;
                state_q  <= ST_SCAN;
              end
              dbba_pkg::KIND_FORMAT: begin
                status_q <= dbba_pkg::STATUS_OK;
                free_q   <= FCW'(NUM_BLOCKS);
                state_q  <= ST_FINISH;
              end
              default: begin
                status_q <= dbba_pkg::STATUS_OK;
                state_q  <= ST_FINISH;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (take) begin
            got_q  <= 8'(got_q + 8'd1);
            free_q <= free_q - FCW'(1);
            if (got_q == 8'd0) begin
              lowest_q <= idx_q;
            end
          end
          if (release_blk) begin
            free_q <= free_q + FCW'(1);
          end
          if (idx_q == IDXW'(NUM_BLOCKS - 1)) begin
            state_q <= ST_FINISH;
          end else begin
            idx_q <= idx_q + IDXW'(1);
          end
        end
        ST_FINISH: begin
          if (out_free_slot) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_start_q  <= lowest_w[6:0];
            out_free_q   <= free_w[7:0];
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.start_block = out_start_q;
  assign rsp_o.free_count  = out_free_q;

  // free count never exceeds the number of blocks
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= FCW'(NUM_BLOCKS))
    else $error("free count above block count");

  // allocation never claims more than requested
  a_got_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && op_alloc_q) |-> (got_q <= want_q))
    else $error("allocation overran request");

  // an admitted allocation is fully satisfied by the end of the scan
  a_alloc_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && op_alloc_q && idx_q == IDXW'(NUM_BLOCKS - 1))
      |=> (got_q == want_q))
    else $error("allocation short after full scan");

  // oversize allocation is rejected without a scan
  a_no_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req_i.kind == dbba_pkg::KIND_ALLOC &&
     {{(CW-8){1'b0}}, req_i.block_count} > CW'(free_q))
      |=> (state_q == ST_FINISH && status_q == dbba_pkg::STATUS_NO_SPACE))
    else $error("no-space allocation not rejected");

endmodule

FILE: src/dbba_cell.sv
module dbba_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dbba_pkg::chain_ctrl_t ctrl_i,
  input  logic                  used_i,
  output logic                  used_o
);

  logic used_q;

  // one used bit; takes the neighbor's bit on every shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      used_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      used_q <= used_i;
    end
  end

  assign used_o = used_q;

endmodule

FILE: src/dbba_chain.sv
module dbba_chain #(
  parameter int unsigned NUM_BLOCKS = dbba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dbba_pkg::chain_ctrl_t ctrl_i,
  input  logic                  tail_i,  // processed head bit, written back at the tail
  output logic                  head_o   // bit of the block under the sequencer
);

  logic [NUM_BLOCKS-1:0] used;

  // ring of cells: each cell loads from its upper neighbor, the last from the sequencer
  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    logic nbr;
    if (i == NUM_BLOCKS - 1) begin : g_tail
      assign nbr = tail_i;
    end else begin : g_mid
      assign nbr = used[i+1];
    end
    dbba_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_i),
      .used_i (nbr),
      .used_o (used[i])
    );
  end

  assign head_o = used[0];

endmodule
